### src/order_table_engine_unit_assert.svh
// Assertion macros for the order table engine.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ORDER_TABLE_ENGINE_UNIT_ASSERT_SVH
`define ORDER_TABLE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define OTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order table check failed");

// Next-cycle implication under synchronous active-low reset.
`define OTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order table check failed");

`endif

### src/ote_pkg.sv
// Shared types and codes for the order table engine.
// No dependencies; used by ote_cell and order_table_engine_unit.
package ote_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int BUCKETS_DEF     = 10;
    // bucket index width, enough for the largest supported bucket count
    localparam int BKT_W           = 6;

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_CANCEL  = 3'd1;
    localparam logic [2:0] ACT_REDUCE  = 3'd2;
    localparam logic [2:0] ACT_REPLACE = 3'd3;
    localparam logic [2:0] ACT_DUMP    = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_RECORD    = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    typedef struct packed {
        logic [31:0]      id;
        logic [7:0]       side;
        logic [31:0]      qty;
        logic [31:0]      price;
        logic [BKT_W-1:0] bkt;
    } entry_t;

    typedef struct packed {
        logic add_we;
        logic shift;
        logic drop;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WRITE,
        S_WALK,
        S_FLUSH,
        S_RESP
    } state_t;

endpackage

### src/order_table_engine_unit.sv
// Order table engine top level: stream in/out, APB register, FSM over a ring of cells.
// Depends on ote_pkg, ote_cell and order_table_engine_unit_assert.svh.
// Orders live packed, oldest first, in a row of cells that rotates one place per cycle
// through the head cell, unless a dump is held by a stalled result side. Add runs
// through accept, four byte steps of id mod BUCKETS for the bucket tag, the write and
// the status beat. For cancel, reduce and replace the ring turns once and the first
// head with a matching id is dropped or rewritten. Dump turns the ring once in list
// mode and once per bucket in hash mode. Add to a full table and dump of an empty one
// go straight to the status beat; unused action codes give no beat.
// One item is worked at a time.
`include "order_table_engine_unit_assert.svh"

module order_table_engine_unit #(
    parameter int TABLE_DEPTH = ote_pkg::TABLE_DEPTH_DEF,
    parameter int BUCKETS     = ote_pkg::BUCKETS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] order_id, [39:32] side, [70:40] quantity, [102:71] price, [103] zero
    input  logic [103:0] s_tdata,
    // [2:0] action
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] out_id, [39:32] out_side, [71:40] out_quantity, [103:72] out_price
    output logic [103:0] m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = ote_pkg::BKT_W;

    ote_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   steps_reg, steps_next;
    logic [BW-1:0]   bkt_reg, bkt_next;
    logic [BW-1:0]   rem_reg, rem_next;
    logic [1:0]      bitc_reg, bitc_next;
    logic [2:0]      act_reg, act_next;
    logic [31:0]     id_reg, id_next;
    logic [7:0]      side_reg, side_next;
    logic [30:0]     qty_reg, qty_next;
    logic [31:0]     price_reg, price_next;
    logic            found_reg, found_next;
    logic [2:0]      resp_reg, resp_next;
    logic            hold_vld_reg, hold_vld_next;
    ote_pkg::entry_t hold_reg, hold_next;
    logic            mv_reg, mv_next;
    logic [2:0]      mstat_reg, mstat_next;
    logic            mlast_reg, mlast_next;
    ote_pkg::entry_t mout_reg, mout_next;
    logic            hash_reg, hash_next;

    ote_pkg::cell_ctl_t ctl;
    ote_pkg::entry_t    cell_q [TABLE_DEPTH];
    ote_pkg::entry_t    head, head_mod, add_e;

    logic            out_free, hit, emit, cfg_wr;
    logic [BW-1:0]   rem_x256 [1 << BW];
    logic [BW-1:0]   byte_mod [256];
    logic [7:0]      id_byte;
    logic [BW:0]     rem_sum;
    logic [32:0]     red_diff;

    assign head = cell_q[0];

    // ring of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == TABLE_DEPTH - 1) begin : g_last
            ote_cell #(.IDX(i), .CW(CW)) u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .cnt     (cnt_reg),
                .right_i (head_mod),
                .wrap_i  (head_mod),
                .add_i   (add_e),
                .q_o     (cell_q[i])
            );
        end else begin : g_mid
            ote_cell #(.IDX(i), .CW(CW)) u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .cnt     (cnt_reg),
                .right_i (cell_q[i+1]),
                .wrap_i  (head_mod),
                .add_i   (add_e),
                .q_o     (cell_q[i])
            );
        end
    end

    assign add_e = '{id: id_reg, side: side_reg, qty: {1'b0, qty_reg},
                     price: price_reg, bkt: rem_reg};

    // saturating reduce: signed quantity minus unsigned amount
    assign red_diff = {head.qty[31], head.qty} - {2'b00, qty_reg};
    assign hit      = !found_reg && (head.id == id_reg);

    always_comb begin
        head_mod = head;
        if (hit && act_reg == ote_pkg::ACT_REDUCE) begin
            head_mod.qty = (red_diff[32] != red_diff[31]) ? 32'h8000_0000 : red_diff[31:0];
        end else if (hit && act_reg == ote_pkg::ACT_REPLACE) begin
            head_mod.qty   = {1'b0, qty_reg};
            head_mod.price = price_reg;
        end
    end

    // id mod BUCKETS one byte per cycle, MSB first:
    // rem' = ((rem * 256) mod BUCKETS + byte mod BUCKETS) mod BUCKETS, from constant tables
    for (genvar r = 0; r < (1 << BW); r++) begin : g_rem_tab
        assign rem_x256[r] = BW'((r * 256) % BUCKETS);
    end
    for (genvar b = 0; b < 256; b++) begin : g_byte_tab
        assign byte_mod[b] = BW'(b % BUCKETS);
    end

    always_comb begin
        case (bitc_reg)
            2'd0:    id_byte = id_reg[31:24];
            2'd1:    id_byte = id_reg[23:16];
            2'd2:    id_byte = id_reg[15:8];
            default: id_byte = id_reg[7:0];
        endcase
    end

    assign rem_sum = {1'b0, rem_x256[rem_reg]} + {1'b0, byte_mod[id_byte]};

    assign out_free = !mv_reg || m_tready;
    assign emit     = !hash_reg || (head.bkt == bkt_reg);
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        steps_next    = steps_reg;
        bkt_next      = bkt_reg;
        rem_next      = rem_reg;
        bitc_next     = bitc_reg;
        act_next      = act_reg;
        id_next       = id_reg;
        side_next     = side_reg;
        qty_next      = qty_reg;
        price_next    = price_reg;
        found_next    = found_reg;
        resp_next     = resp_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        mv_next       = mv_reg;
        mstat_next    = mstat_reg;
        mlast_next    = mlast_reg;
        mout_next     = mout_reg;
        hash_next     = hash_reg;
        ctl           = '0;

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        if (cfg_wr && paddr[2] == 1'b0) begin
            hash_next = pwdata[0];
        end

        case (state_reg)
            ote_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tuser;
                    id_next    = s_tdata[31:0];
                    side_next  = s_tdata[39:32];
                    qty_next   = s_tdata[70:40];
                    price_next = s_tdata[102:71];
                    found_next = 1'b0;
                    steps_next = cnt_reg;
                    bkt_next   = '0;
                    case (s_tuser)
                        ote_pkg::ACT_ADD: begin
                            if (cnt_reg == CW'(TABLE_DEPTH)) begin
                                resp_next  = ote_pkg::STAT_FULL;
                                state_next = ote_pkg::S_RESP;
                            end else begin
                                rem_next   = '0;
                                bitc_next  = '0;
                                state_next = ote_pkg::S_MOD;
                            end
                        end
                        ote_pkg::ACT_CANCEL, ote_pkg::ACT_REDUCE,
                        ote_pkg::ACT_REPLACE: begin
                            state_next = ote_pkg::S_WALK;
                        end
                        ote_pkg::ACT_DUMP: begin
                            if (cnt_reg == '0) begin
                                resp_next  = ote_pkg::STAT_EMPTY;
                                state_next = ote_pkg::S_RESP;
                            end else begin
                                state_next = ote_pkg::S_WALK;
                            end
                        end
                        default: begin
                            state_next = ote_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ote_pkg::S_MOD: begin
                rem_next  = (rem_sum >= (BW+1)'(BUCKETS)) ?
                            BW'(rem_sum - (BW+1)'(BUCKETS)) : BW'(rem_sum);
                bitc_next = bitc_reg + 2'd1;
                if (bitc_reg == 2'd3) begin
                    state_next = ote_pkg::S_WRITE;
                end
            end
            ote_pkg::S_WRITE: begin
                ctl.add_we = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                resp_next  = ote_pkg::STAT_OK;
                state_next = ote_pkg::S_RESP;
            end
            ote_pkg::S_WALK: begin
                if (steps_reg == '0) begin
                    if (act_reg == ote_pkg::ACT_DUMP) begin
                        if (hash_reg && bkt_reg != BW'(BUCKETS - 1)) begin
                            bkt_next   = bkt_reg + BW'(1);
                            steps_next = cnt_reg;
                        end else begin
                            state_next = ote_pkg::S_FLUSH;
                        end
                    end else begin
                        resp_next  = found_reg ? ote_pkg::STAT_OK : ote_pkg::STAT_NOT_FOUND;
                        state_next = ote_pkg::S_RESP;
                    end
                end else if (act_reg == ote_pkg::ACT_DUMP) begin
                    // keep one record back so the final one can carry tlast
                    if (!(emit && hold_vld_reg && !out_free)) begin
                        ctl.shift  = 1'b1;
                        steps_next = steps_reg - CW'(1);
                        if (emit) begin
                            if (hold_vld_reg) begin
                                mv_next    = 1'b1;
                                mout_next  = hold_reg;
                                mstat_next = ote_pkg::STAT_RECORD;
                                mlast_next = 1'b0;
                            end
                            hold_next     = head;
                            hold_vld_next = 1'b1;
                        end
                    end
                end else begin
                    ctl.shift  = 1'b1;
                    steps_next = steps_reg - CW'(1);
                    if (hit) begin
                        found_next = 1'b1;
                        if (act_reg == ote_pkg::ACT_CANCEL) begin
                            ctl.drop = 1'b1;
                            cnt_next = cnt_reg - CW'(1);
                        end
                    end
                end
            end
            ote_pkg::S_FLUSH: begin
                if (out_free) begin
                    mv_next       = 1'b1;
                    mout_next     = hold_reg;
                    mstat_next    = ote_pkg::STAT_RECORD;
                    mlast_next    = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = ote_pkg::S_IDLE;
                end
            end
            ote_pkg::S_RESP: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mout_next  = '0;
                    mstat_next = resp_reg;
                    mlast_next = 1'b1;
                    state_next = ote_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ote_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ote_pkg::S_IDLE;
            cnt_reg      <= '0;
            hold_vld_reg <= 1'b0;
            mv_reg       <= 1'b0;
            hash_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            hold_vld_reg <= hold_vld_next;
            mv_reg       <= mv_next;
            hash_reg     <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg <= steps_next;
        bkt_reg   <= bkt_next;
        rem_reg   <= rem_next;
        bitc_reg  <= bitc_next;
        act_reg   <= act_next;
        id_reg    <= id_next;
        side_reg  <= side_next;
        qty_reg   <= qty_next;
        price_reg <= price_next;
        found_reg <= found_next;
        resp_reg  <= resp_next;
        hold_reg  <= hold_next;
        mstat_reg <= mstat_next;
        mlast_reg <= mlast_next;
        mout_reg  <= mout_next;
    end

    assign s_tready = (state_reg == ote_pkg::S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = mstat_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {mout_reg.price, mout_reg.qty, mout_reg.side, mout_reg.id};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {31'd0, hash_reg} : 32'd0;

    `OTE_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(TABLE_DEPTH))
    `OTE_ASSERT_IMP(a_idle_no_hold, aclk, aresetn, s_tready, !hold_vld_reg)
    `OTE_ASSERT_IMP(a_status_zero, aclk, aresetn,
                    mv_reg && mstat_reg != ote_pkg::STAT_RECORD,
                    mout_reg == '0 && mlast_reg)
    `OTE_ASSERT_NXT(a_add_goes_mod, aclk, aresetn,
                    s_tvalid && s_tready && s_tuser == ote_pkg::ACT_ADD &&
                    cnt_reg != CW'(TABLE_DEPTH),
                    state_reg == ote_pkg::S_MOD)

endmodule

### src/ote_cell.sv
// One slot of the order ring: holds an entry, loads on add, shifts left on a walk.
// Depends on ote_pkg.
module ote_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                aclk,
    input  ote_pkg::cell_ctl_t  ctl,
    input  logic [CW-1:0]       cnt,
    input  ote_pkg::entry_t     right_i,
    input  ote_pkg::entry_t     wrap_i,
    input  ote_pkg::entry_t     add_i,
    output ote_pkg::entry_t     q_o
);

    ote_pkg::entry_t q_reg, q_next;

    logic is_add, is_tail, is_inner;

    assign is_add   = (cnt == CW'(IDX));
    assign is_tail  = (cnt == CW'(IDX + 1));
    assign is_inner = (cnt >  CW'(IDX + 1));

    always_comb begin
        q_next = q_reg;
        if (ctl.add_we && is_add) begin
            q_next = add_i;
        end else if (ctl.shift && is_inner) begin
            q_next = right_i;
        end else if (ctl.shift && is_tail && !ctl.drop) begin
            // head wraps around to the tail of the occupied run
            q_next = wrap_i;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q_o = q_reg;

endmodule

### sim/tb_top.sv
// Self-checking bench for order_table_engine_unit: streams order actions, predicts each beat.
// Depends on ote_pkg and the RTL; APB write of the dump-order register between phases.
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH = 64;
    localparam int NBKT  = 10;

    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] id;
        logic [7:0]  side;
        logic [30:0] qty;
        logic [31:0] price;
    } order_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] id;
        logic [7:0]  side;
        logic [31:0] qty;
        logic [31:0] price;
        logic        last;
    } book_beat_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    order_table_engine_unit dut (.*);

    // predictor state
    logic        bk_hash;
    int          bk_count;
    logic [31:0] bk_id    [DEPTH];
    logic [7:0]  bk_side  [DEPTH];
    logic [31:0] bk_qty   [DEPTH];
    logic [31:0] bk_price [DEPTH];

    order_req_t  pending_orders[$];
    book_beat_t  expected_beats[$];
    int          err_count;
    int          accepted;
    logic        drv_enable;
    int          drv_gap;
    int          rcv_gap;
    int          rcv_hold;

    function automatic book_beat_t status_beat(logic [2:0] st);
        book_beat_t b;
        b = '0;
        b.status = st;
        b.last = 1'b1;
        return b;
    endfunction

    function automatic int find_order(logic [31:0] id);
        for (int i = 0; i < bk_count; i++)
            if (bk_id[i] == id) return i;
        return -1;
    endfunction

    task automatic push_record(int i);
        book_beat_t b;
        b = '0;
        b.status = ote_pkg::STAT_RECORD;
        b.id = bk_id[i];
        b.side = bk_side[i];
        b.qty = bk_qty[i];
        b.price = bk_price[i];
        expected_beats.push_back(b);
    endtask

    task automatic apply_order(order_req_t r);
        int     slot;
        longint v;
        book_beat_t b;
        slot = (r.act inside {ote_pkg::ACT_CANCEL, ote_pkg::ACT_REDUCE, ote_pkg::ACT_REPLACE})
               ? find_order(r.id) : 0;
        case (r.act)
            ote_pkg::ACT_ADD: begin
                if (bk_count >= DEPTH) begin
                    expected_beats.push_back(status_beat(ote_pkg::STAT_FULL));
                end else begin
                    bk_id[bk_count] = r.id;
                    bk_side[bk_count] = r.side;
                    bk_qty[bk_count] = {1'b0, r.qty};
                    bk_price[bk_count] = r.price;
                    bk_count++;
                    expected_beats.push_back(status_beat(ote_pkg::STAT_OK));
                end
            end
            ote_pkg::ACT_CANCEL, ote_pkg::ACT_REDUCE, ote_pkg::ACT_REPLACE: begin
                if (slot < 0) begin
                    expected_beats.push_back(status_beat(ote_pkg::STAT_NOT_FOUND));
                end else begin
                    if (r.act == ote_pkg::ACT_CANCEL) begin
                        for (int i = slot; i + 1 < bk_count; i++) begin
                            bk_id[i] = bk_id[i+1];
                            bk_side[i] = bk_side[i+1];
                            bk_qty[i] = bk_qty[i+1];
                            bk_price[i] = bk_price[i+1];
                        end
                        bk_count--;
                    end else if (r.act == ote_pkg::ACT_REDUCE) begin
                        v = longint'($signed(bk_qty[slot])) - longint'(r.qty);
                        if (v < -64'sd2147483648) v = -64'sd2147483648;
                        bk_qty[slot] = v[31:0];
                    end else begin
                        bk_qty[slot] = {1'b0, r.qty};
                        bk_price[slot] = r.price;
                    end
                    expected_beats.push_back(status_beat(ote_pkg::STAT_OK));
                end
            end
            ote_pkg::ACT_DUMP: begin
                if (bk_count == 0) begin
                    expected_beats.push_back(status_beat(ote_pkg::STAT_EMPTY));
                end else begin
                    if (bk_hash) begin
                        for (int k = 0; k < NBKT; k++)
                            for (int i = 0; i < bk_count; i++)
                                if (bk_id[i] % NBKT == k) push_record(i);
                    end else begin
                        for (int i = 0; i < bk_count; i++) push_record(i);
                    end
                    b = expected_beats.pop_back();
                    b.last = 1'b1;
                    expected_beats.push_back(b);
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        order_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                r = {s_tuser, s_tdata[31:0], s_tdata[39:32], s_tdata[70:40], s_tdata[102:71]};
                apply_order(r);
                accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat
            end else if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                s_tvalid <= 1'b0;
            end else if (drv_enable && pending_orders.size() > 0) begin
                r = pending_orders.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= r.act;
                s_tdata <= {1'b0, r.price, r.qty, r.side, r.id};
                drv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge aclk) begin
        book_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rcv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.id) report_mismatch("id", m_tdata[31:0], want.id);
                    if (m_tdata[39:32] !== want.side)
                        report_mismatch("side", 32'(m_tdata[39:32]), 32'(want.side));
                    if (m_tdata[71:40] !== want.qty)
                        report_mismatch("quantity", m_tdata[71:40], want.qty);
                    if (m_tdata[103:72] !== want.price)
                        report_mismatch("price", m_tdata[103:72], want.price);
                    if (m_tlast !== want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
            if (rcv_hold > 0) begin
                rcv_hold <= rcv_hold - 1;
                m_tready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap <= rcv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    rcv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            end
        end
    end

    function automatic order_req_t mk(logic [2:0] a, logic [31:0] id, logic [7:0] sd,
                                      logic [30:0] q, logic [31:0] p);
        order_req_t r;
        r.act = a; r.id = id; r.side = sd; r.qty = q; r.price = p;
        return r;
    endfunction

    // ids from a small pool so that actions hit, plus odd random ids
    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 7) == 0) return $urandom();
        return $urandom_range(0, 23);
    endfunction

    function automatic order_req_t rand_order();
        int sel;
        logic [2:0] a;
        sel = $urandom_range(0, 99);
        if (sel < 35) a = ote_pkg::ACT_ADD;
        else if (sel < 50) a = ote_pkg::ACT_CANCEL;
        else if (sel < 68) a = ote_pkg::ACT_REDUCE;
        else if (sel < 83) a = ote_pkg::ACT_REPLACE;
        else if (sel < 95) a = ote_pkg::ACT_DUMP;
        else a = 3'($urandom_range(5, 7));
        return mk(a, pick_id(), 8'($urandom()), 31'($urandom()), $urandom());
    endfunction

    // sampled at the falling edge so the driver's update of the edge is already visible
    task automatic wait_drained();
        while (pending_orders.size() > 0 || s_tvalid || expected_beats.size() > 0)
            @(negedge aclk);
        repeat (DEPTH * NBKT + 80) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        bk_hash = (addr == 3'd0) ? data[0] : bk_hash;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        bk_hash = 1'b0; bk_count = 0; err_count = 0; accepted = 0;
        drv_enable = 1'b1; rcv_hold = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty dump, misses, extremes, duplicates, saturation
        pending_orders.push_back(mk(ote_pkg::ACT_DUMP, 0, 0, 0, 0));
        pending_orders.push_back(mk(ote_pkg::ACT_CANCEL, 5, 0, 0, 0));
        pending_orders.push_back(mk(ote_pkg::ACT_REDUCE, 5, 0, 1, 0));
        pending_orders.push_back(mk(ote_pkg::ACT_REPLACE, 5, 0, 1, 1));
        pending_orders.push_back(mk(ote_pkg::ACT_ADD, 32'hFFFF_FFFF, 8'hFF, 31'h7FFF_FFFF,
                                    32'hFFFF_FFFF));
        pending_orders.push_back(mk(ote_pkg::ACT_ADD, 0, 8'h00, 0, 0));
        pending_orders.push_back(mk(ote_pkg::ACT_ADD, 7, 8'h42, 100, 12345));
        pending_orders.push_back(mk(ote_pkg::ACT_ADD, 7, 8'h53, 200, 54321));
        pending_orders.push_back(mk(ote_pkg::ACT_ADD, 13, 8'hAA, 31'h2AAA_AAAA, 32'h5555_5555));
        pending_orders.push_back(mk(ote_pkg::ACT_REDUCE, 7, 0, 31'h7FFF_FFFF, 0));
        pending_orders.push_back(mk(ote_pkg::ACT_REDUCE, 7, 0, 31'h7FFF_FFFF, 0));
        pending_orders.push_back(mk(ote_pkg::ACT_REPLACE, 7, 0, 31'h5555_5555, 32'hAAAA_AAAA));
        pending_orders.push_back(mk(ote_pkg::ACT_DUMP, 0, 0, 0, 0));
        pending_orders.push_back(mk(ote_pkg::ACT_CANCEL, 7, 0, 0, 0));
        pending_orders.push_back(mk(3'd5, 1, 1, 1, 1));
        pending_orders.push_back(mk(3'd7, 1, 1, 1, 1));
        pending_orders.push_back(mk(ote_pkg::ACT_DUMP, 0, 0, 0, 0));
        wait_drained();
        apb_write(3'd0, 32'd1);
        apb_write(3'd4, 32'd0);   // unused register
        pending_orders.push_back(mk(ote_pkg::ACT_DUMP, 0, 0, 0, 0));
        // fill past capacity to hit table full
        for (int i = 0; i < DEPTH + 2; i++)
            pending_orders.push_back(mk(ote_pkg::ACT_ADD, $urandom_range(0, 40), 8'($urandom()),
                                        31'($urandom()), $urandom()));
        pending_orders.push_back(mk(ote_pkg::ACT_DUMP, 0, 0, 0, 0));
        wait_drained();

        // random phases across both dump orders; one long receiver hold
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(3'd0, ph[0] ? 32'd0 : 32'hFFFF_FFFF);
            for (int n = 0; n < 40; n++) pending_orders.push_back(rand_order());
            if (ph == 1) rcv_hold = 400;
            if (ph == 2) begin
                // sender stops until everything outstanding has come back
                while (pending_orders.size() > 20) @(posedge aclk);
                drv_enable = 1'b0;
                @(negedge aclk);
                while (s_tvalid || expected_beats.size() > 0) @(negedge aclk);
                drv_enable = 1'b1;
            end
            wait_drained();
        end

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end
endmodule

### order_table_engine_unit.f
+incdir+src
src/ote_pkg.sv
src/ote_cell.sv
src/order_table_engine_unit.sv
sim/tb_top.sv
